/* rtl/core/binary_to_decimal_ascii_defines.svh */
// Assertion macros shared by the checker of the decimal text converter
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define B2DA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b2da: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define B2DA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b2da: next-cycle check failed");

`endif

/* rtl/core/b2da_pkg.sv */
// Shared types and constants of the binary to decimal ASCII converter
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W      = $clog2(DATA_W);
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned LEN_W      = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_DONE
  } conv_state_e;

  typedef struct packed {
    logic load_in;
    logic shift;
    logic load_emit;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last_char;
  } dp_status_t;

endpackage

/* rtl/core/b2da_datapath.sv */
// Datapath: magnitude, bit-serial double dabble and character emit registers
`timescale 1ns / 1ps

module b2da_datapath (
  input  logic                           clk_i,
  input  logic [b2da_pkg::DATA_W-1:0]    value_bits_i,
  input  logic                           is_signed_i,
  input  b2da_pkg::dp_cmd_t              cmd_i,
  output b2da_pkg::dp_status_t           status_o,
  output logic [b2da_pkg::CHAR_W-1:0]    text_char_o,
  output logic                           is_last_o,
  output logic [b2da_pkg::LEN_W-1:0]     text_length_o
);

  // Conversion side
  logic [b2da_pkg::DATA_W-1:0]              bin_q, bin_d;
  logic [b2da_pkg::NUM_DIGITS-1:0][3:0]     bcd_q, bcd_d;
  logic                                     neg_q, neg_d;

  // Emit side
  logic [b2da_pkg::NUM_DIGITS-1:0][3:0]     ebcd_q, ebcd_d;
  logic                                     eneg_q, eneg_d;
  logic [b2da_pkg::LEN_W-1:0]               elen_q, elen_d;
  logic [b2da_pkg::LEN_W-1:0]               eidx_q, eidx_d;

  logic                                     in_neg;
  logic [b2da_pkg::NUM_DIGITS-1:0][3:0]     adj;
  logic [4*b2da_pkg::NUM_DIGITS-1:0]        adj_flat;
  logic [b2da_pkg::LEN_W-1:0]               ndig;
  logic [b2da_pkg::LEN_W-1:0]               text_len;
  logic [b2da_pkg::LEN_W-1:0]               dsel_full;
  logic [b2da_pkg::DIGIT_IDX_W-1:0]         dsel;
  logic [3:0]                               cur_digit;

  assign in_neg = is_signed_i & value_bits_i[b2da_pkg::DATA_W-1];

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  assign adj_flat = adj;

  // Digit count: highest nonzero digit, at least one digit
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[i] != 4'd0) begin
        ndig = b2da_pkg::LEN_W'(i + 1);
      end
    end
    text_len = ndig + {{(b2da_pkg::LEN_W-1){1'b0}}, neg_q};
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    ebcd_d = ebcd_q;
    eneg_d = eneg_q;
    elen_d = elen_q;
    eidx_d = eidx_q;
    if (cmd_i.load_in) begin
      bin_d = in_neg ? (~value_bits_i + 32'd1) : value_bits_i;
      bcd_d = '0;
      neg_d = in_neg;
    end else if (cmd_i.shift) begin
      bcd_d = {adj_flat[4*b2da_pkg::NUM_DIGITS-2:0], bin_q[b2da_pkg::DATA_W-1]};
      bin_d = {bin_q[b2da_pkg::DATA_W-2:0], 1'b0};
    end
    if (cmd_i.load_emit) begin
      ebcd_d = bcd_q;
      eneg_d = neg_q;
      elen_d = text_len;
      eidx_d = '0;
    end else if (cmd_i.advance) begin
      eidx_d = eidx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    ebcd_q <= ebcd_d;
    eneg_q <= eneg_d;
    elen_q <= elen_d;
    eidx_q <= eidx_d;
  end

  // Character at position eidx: sign first, then digits from the top down
  assign dsel_full = elen_q - 4'd1 - eidx_q;
  assign dsel      = dsel_full[b2da_pkg::DIGIT_IDX_W-1:0];
  assign cur_digit = ebcd_q[dsel];

  always_comb begin
    if (eneg_q && (eidx_q == 4'd0)) begin
      text_char_o = b2da_pkg::ASCII_MINUS;
    end else begin
      text_char_o = b2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
    end
  end

  assign is_last_o          = (eidx_q == (elen_q - 4'd1));
  assign text_length_o      = elen_q;
  assign status_o.last_char = is_last_o;

endmodule

/* rtl/core/b2da_ctrl.sv */
// Controller: conversion sequencer and emit handshake
`timescale 1ns / 1ps

module b2da_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  b2da_pkg::dp_status_t   status_i,
  output b2da_pkg::dp_cmd_t      cmd_o
);

  b2da_pkg::conv_state_e          state_q, state_d;
  logic [b2da_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           out_beat;

  assign out_valid_o = busy_q;
  assign out_beat    = busy_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b2da_pkg::CV_IDLE;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    busy_d        = busy_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    cmd_o.advance = out_beat;
    if (out_beat && status_i.last_char) begin
      busy_d = 1'b0;
    end
    case (state_q)
      b2da_pkg::CV_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = b2da_pkg::CV_SHIFT;
        end
      end
      b2da_pkg::CV_SHIFT: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == b2da_pkg::CNT_W'(b2da_pkg::DATA_W - 1)) begin
          state_d = b2da_pkg::CV_DONE;
        end
      end
      b2da_pkg::CV_DONE: begin
        // Hand the digits over once the emitter has drained
        if (!busy_q) begin
          cmd_o.load_emit = 1'b1;
          busy_d          = 1'b1;
          state_d         = b2da_pkg::CV_IDLE;
        end
      end
      default: begin
        state_d = b2da_pkg::CV_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/binary_to_decimal_ascii.sv */
// Sequence: the input beat is taken, the 32 shift steps run, then the
// hand-over to the emit registers, after which the first character is valid.
// Each word runs load, 32-step shift-add-3 loop and hand-over; the next word
// converts while the previous text takes up to 11 output beats; output
// stalls that outlast the conversion hold the converter in its hand-over state.
// Reset: rst_ni is asynchronous, active low; it clears the sequencer and the
// emit-busy flag, leaving no item in flight.
`timescale 1ns / 1ps

// Top level: 32-bit word to decimal ASCII text, one character per beat
module binary_to_decimal_ascii (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [b2da_pkg::DATA_W-1:0]    value_bits_i,
  input  logic                           is_signed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [b2da_pkg::CHAR_W-1:0]    text_char_o,
  output logic                           is_last_o,
  output logic [b2da_pkg::LEN_W-1:0]     text_length_o
);

  // Commands from the sequencer, status back from the datapath
  b2da_pkg::dp_cmd_t    cmd;
  b2da_pkg::dp_status_t status;

  // Sequencer: takes a beat when idle, runs the 32 shift steps, then hands
  // the digits to the emit registers once the previous text has drained.
  b2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: the magnitude is formed in 32 unsigned bits, so the most
  // negative signed word converts without overflow. The emit registers
  // are separate from the conversion registers, so the next word converts
  // while the current text goes out.
  b2da_datapath u_datapath (
    .clk_i         (clk_i),
    .value_bits_i  (value_bits_i),
    .is_signed_i   (is_signed_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .text_char_o   (text_char_o),
    .is_last_o     (is_last_o),
    .text_length_o (text_length_o)
  );

endmodule

/* rtl/core/b2da_checker.sv */
// Port-level checker for the converter, bound to the top level
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [b2da_pkg::CHAR_W-1:0]    text_char_o,
  input logic                           is_last_o,
  input logic [b2da_pkg::LEN_W-1:0]     text_length_o
);

  logic out_beat;
  logic single_ok;

  assign out_beat  = out_valid_o & ~out_stall_i;
  assign single_ok = is_last_o && (text_char_o != b2da_pkg::ASCII_MINUS);

  // Hold off new input while a taken word converts
  `B2DA_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o)

  // Hold a stalled output beat
  `B2DA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(text_char_o))

  // A text never breaks up: the next character follows with the same length
  `B2DA_ASSERT_NEXT(a_text_cont, out_beat && !is_last_o, out_valid_o && $stable(text_length_o))

  // The minus sign only opens a text
  `B2DA_ASSERT_NEXT(a_sign_first, out_beat && !is_last_o, text_char_o != b2da_pkg::ASCII_MINUS)

  // A text of one character is a single digit
  `B2DA_ASSERT_NOW(a_single, out_valid_o && text_length_o == 4'd1, single_ok)

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
